FILE: rtl/core/lcdnw_pkg.sv
`default_nettype none

package lcdnw_pkg;

	// action codes on the input tuser
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_INIT  = 2'd2;

	// target codes
	localparam logic [1:0] TGT_ONE  = 2'd0;
	localparam logic [1:0] TGT_TWO  = 2'd1;
	localparam logic [1:0] TGT_BOTH = 2'd2;

	// register indexes on the config port
	localparam logic [1:0] REG_PULSE     = 2'd0;
	localparam logic [1:0] REG_CMD_WAIT  = 2'd1;
	localparam logic [1:0] REG_POWER_UP  = 2'd2;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [15:0] PULSE_RESET    = 16'd200;
	localparam logic [23:0] CMD_WAIT_RESET = 24'd2000;
	localparam logic [23:0] POWER_UP_RESET = 24'd100000;

	localparam logic [3:0] INIT_COUNT = 4'd9;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_POWER  = 7'b0000010,
		PH_HI_EN  = 7'b0000100,
		PH_HI_GAP = 7'b0001000,
		PH_LO_EN  = 7'b0010000,
		PH_LO_GAP = 7'b0100000,
		PH_SETTLE = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [15:0] pulse_ticks;
		logic [23:0] command_wait_ticks;
		logic [23:0] power_up_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] value;
		logic       is_data;
		logic [1:0] target;
	} item_t;

	typedef struct packed {
		logic [3:0] data_nibble;
		logic       reg_select;
		logic       enable_one;
		logic       enable_two;
		logic       busy_res;
		logic       accepted;
	} result_t;

	// power-on command sequence, sent to both chips
	function automatic logic [7:0] init_cmd(input logic [3:0] step);
		logic [7:0] cmd;
		case (step)
			4'd0: cmd = 8'h33;
			4'd1: cmd = 8'h32;
			4'd2: cmd = 8'h28;
			4'd3: cmd = 8'h28;
			4'd4: cmd = 8'h28;
			4'd5: cmd = 8'h0C;
			4'd6: cmd = 8'h01;
			4'd7: cmd = 8'h06;
			4'd8: cmd = 8'h80;
			default: cmd = 8'h00;
		endcase
		return cmd;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/char_lcd_nibble_writer_top.sv
`default_nettype none

// channel   dir   beat contents
// s_*       in    one item: tick, byte write request or init request
// m_*       out   one result per item: pin levels, busy, accepted
// apb       in    register writes and reads, always ready
//
// one item per cycle sustained while the output is not stalled; each item waits in the input
// register and its result is registered into the output register when the item moves on
// arst_n clears the sequencer to idle and the registers to their defaults
// a stalled result holds the output register; the input register keeps
// filling until both are full, then s_tready drops

module char_lcd_nibble_writer_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// stream in
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [15:0]                        s_tdata,  // value[7:0], is_data[8], target[10:9]
	input  wire logic [1:0]                         s_tuser,  // action[1:0]
	// stream out
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic      [15:0]                        m_tdata,  // data_nibble[3:0], reg_select[4],
	                                                          // enable_one[5], enable_two[6],
	                                                          // busy_res[7], accepted[8]
	// register port
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [lcdnw_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [lcdnw_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [lcdnw_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                    pready
);

	lcdnw_pkg::cfg_t    cfg;
	lcdnw_pkg::item_t   item_s1;
	lcdnw_pkg::result_t result;
	logic               valid_s1;
	logic               out_valid_q;
	logic               advance;
	logic               in_beat;

	// an item moves on when the output register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_beat  = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			item_s1.action  <= s_tuser;
			item_s1.value   <= s_tdata[7:0];
			item_s1.is_data <= s_tdata[8];
			item_s1.target  <= s_tdata[10:9];
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, result.accepted, result.busy_res, result.enable_two,
		result.enable_one, result.reg_select, result.data_nibble};

	lcdnw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer state and result register
	lcdnw_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

endmodule

`default_nettype wire

FILE: rtl/core/lcdnw_cfg.sv
`default_nettype none

module lcdnw_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [lcdnw_pkg::CFG_ADDR_W-1:0]  paddr,
	input  wire logic [lcdnw_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic      [lcdnw_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                                    pready,
	output lcdnw_pkg::cfg_t                         cfg
);

	logic [1:0] reg_idx;
	logic       wr_en;
	lcdnw_pkg::cfg_t cfg_q;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_ticks        <= lcdnw_pkg::PULSE_RESET;
			cfg_q.command_wait_ticks <= lcdnw_pkg::CMD_WAIT_RESET;
			cfg_q.power_up_ticks     <= lcdnw_pkg::POWER_UP_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				lcdnw_pkg::REG_PULSE:    cfg_q.pulse_ticks        <= pwdata[15:0];
				lcdnw_pkg::REG_CMD_WAIT: cfg_q.command_wait_ticks <= pwdata[23:0];
				lcdnw_pkg::REG_POWER_UP: cfg_q.power_up_ticks     <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// read back, the unused register index reads zero
	always_comb begin
		case (reg_idx)
			lcdnw_pkg::REG_PULSE:    prdata = {16'd0, cfg_q.pulse_ticks};
			lcdnw_pkg::REG_CMD_WAIT: prdata = {8'd0, cfg_q.command_wait_ticks};
			lcdnw_pkg::REG_POWER_UP: prdata = {8'd0, cfg_q.power_up_ticks};
			default:                 prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/lcdnw_core.sv
`default_nettype none

module lcdnw_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step_en,
	input  wire lcdnw_pkg::item_t item,
	input  wire lcdnw_pkg::cfg_t  cfg,
	output lcdnw_pkg::result_t    result
);

	typedef struct packed {
		lcdnw_pkg::phase_t phase;
		logic [23:0]       tick_count;
		logic [7:0]        held_byte;
		logic              held_select;
		logic [1:0]        held_target;
		logic [3:0]        init_step;
		logic              init_running;
	} seq_state_t;

	seq_state_t cur_q;
	seq_state_t nxt;
	logic       acc;
	logic [23:0] cnt;
	logic [23:0] len;
	logic [15:0] pulse_eff;
	logic [3:0]  step_inc;
	logic        more_cmds;
	logic        en_high;
	lcdnw_pkg::result_t res;
	lcdnw_pkg::result_t result_s2;

	assign pulse_eff = (cfg.pulse_ticks == 16'd0) ? 16'd1 : cfg.pulse_ticks;
	assign cnt       = cur_q.tick_count + 24'd1;
	assign step_inc  = cur_q.init_step + 4'd1;
	assign more_cmds = cur_q.init_running && (step_inc < lcdnw_pkg::INIT_COUNT);

	always_comb begin
		case (cur_q.phase)
			lcdnw_pkg::PH_POWER:  len = cfg.power_up_ticks;
			lcdnw_pkg::PH_SETTLE: len = cfg.command_wait_ticks;
			default:              len = {8'd0, pulse_eff};
		endcase
	end

	always_comb begin
		nxt = cur_q;
		acc = 1'b0;
		case (item.action)
			lcdnw_pkg::ACT_TICK: begin
				if (cur_q.phase != lcdnw_pkg::PH_IDLE) begin
					if (cnt >= len) begin
						nxt.tick_count = '0;
						case (cur_q.phase)
							lcdnw_pkg::PH_POWER: begin
								nxt.init_step   = '0;
								nxt.held_byte   = lcdnw_pkg::init_cmd(4'd0);
								nxt.held_select = 1'b0;
								nxt.held_target = lcdnw_pkg::TGT_BOTH;
								nxt.phase       = lcdnw_pkg::PH_HI_EN;
							end
							lcdnw_pkg::PH_HI_EN:  nxt.phase = lcdnw_pkg::PH_HI_GAP;
							lcdnw_pkg::PH_HI_GAP: nxt.phase = lcdnw_pkg::PH_LO_EN;
							lcdnw_pkg::PH_LO_EN:  nxt.phase = lcdnw_pkg::PH_LO_GAP;
							lcdnw_pkg::PH_LO_GAP,
							lcdnw_pkg::PH_SETTLE: begin
								if (cur_q.phase == lcdnw_pkg::PH_LO_GAP && !cur_q.held_select
										&& cfg.command_wait_ticks != 24'd0) begin
									nxt.phase = lcdnw_pkg::PH_SETTLE;
								end else if (more_cmds) begin
									nxt.init_step   = step_inc;
									nxt.held_byte   = lcdnw_pkg::init_cmd(step_inc);
									nxt.held_select = 1'b0;
									nxt.held_target = lcdnw_pkg::TGT_BOTH;
									nxt.phase       = lcdnw_pkg::PH_HI_EN;
								end else begin
									nxt.init_running = 1'b0;
									nxt.phase        = lcdnw_pkg::PH_IDLE;
								end
							end
							default: nxt.phase = lcdnw_pkg::PH_IDLE;
						endcase
					end else begin
						nxt.tick_count = cnt;
					end
				end
			end
			lcdnw_pkg::ACT_WRITE: begin
				if (cur_q.phase == lcdnw_pkg::PH_IDLE) begin
					nxt.init_running = 1'b0;
					nxt.held_byte    = item.value;
					nxt.held_select  = item.is_data;
					nxt.held_target  = item.target;
					nxt.phase        = lcdnw_pkg::PH_HI_EN;
					nxt.tick_count   = '0;
					acc              = 1'b1;
				end
			end
			lcdnw_pkg::ACT_INIT: begin
				if (cur_q.phase == lcdnw_pkg::PH_IDLE) begin
					nxt.init_running = 1'b1;
					nxt.init_step    = '0;
					nxt.tick_count   = '0;
					if (cfg.power_up_ticks == 24'd0) begin
						nxt.held_byte   = lcdnw_pkg::init_cmd(4'd0);
						nxt.held_select = 1'b0;
						nxt.held_target = lcdnw_pkg::TGT_BOTH;
						nxt.phase       = lcdnw_pkg::PH_HI_EN;
					end else begin
						nxt.phase = lcdnw_pkg::PH_POWER;
					end
					acc = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// pin levels follow the updated state
	assign en_high = (nxt.phase == lcdnw_pkg::PH_HI_EN) || (nxt.phase == lcdnw_pkg::PH_LO_EN);

	always_comb begin
		if (nxt.phase == lcdnw_pkg::PH_HI_EN || nxt.phase == lcdnw_pkg::PH_HI_GAP) begin
			res.data_nibble = nxt.held_byte[7:4];
		end else begin
			res.data_nibble = nxt.held_byte[3:0];
		end
		res.reg_select = nxt.held_select;
		res.enable_one = en_high && (nxt.held_target == lcdnw_pkg::TGT_ONE
			|| nxt.held_target == lcdnw_pkg::TGT_BOTH);
		res.enable_two = en_high && (nxt.held_target == lcdnw_pkg::TGT_TWO
			|| nxt.held_target == lcdnw_pkg::TGT_BOTH);
		res.busy_res   = (nxt.phase != lcdnw_pkg::PH_IDLE);
		res.accepted   = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.phase        <= lcdnw_pkg::PH_IDLE;
			cur_q.tick_count   <= '0;
			cur_q.held_byte    <= '0;
			cur_q.held_select  <= 1'b0;
			cur_q.held_target  <= '0;
			cur_q.init_step    <= '0;
			cur_q.init_running <= 1'b0;
		end else if (step_en) begin
			cur_q <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			result_s2 <= res;
		end
	end

	assign result = result_s2;

`ifndef SYNTHESIS
	a_idle_no_init: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q.phase == lcdnw_pkg::PH_IDLE |-> !cur_q.init_running)
		else $error("init flag set while idle");

	a_power_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q.phase == lcdnw_pkg::PH_POWER |-> cur_q.init_running)
		else $error("power-up wait outside init");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q.init_step < lcdnw_pkg::INIT_COUNT)
		else $error("init step out of range");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && acc |=> result_s2.busy_res)
		else $error("taken request did not start a sequence");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;

	// codes the package leaves unnamed, driven on purpose
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [1:0] TGT_UNUSED = 2'd3;

	localparam int RUN_LIMIT  = 200000;  // cycles before the run is called hung
	localparam int PHASE_BEATS = 225;    // useful beats per register setting
	localparam int SETTINGS_N  = 7;      // small settings before the extreme one
	localparam int TAIL_BEATS  = 150;    // beats with every register at its maximum

	// power-on command bytes in send order
	localparam logic [7:0] BOOT_SEQ [0:8] = '{
		8'h33, 8'h32, 8'h28, 8'h28, 8'h28, 8'h0C, 8'h01, 8'h06, 8'h80
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // value[7:0], is_data[8], target[10:9]
	logic [1:0]  s_tuser = '0;   // action[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // data_nibble[3:0], reg_select[4], enable_one[5],
	                             // enable_two[6], busy_res[7], accepted[8]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [lcdnw_pkg::CFG_ADDR_W-1:0] paddr = '0;
	logic [lcdnw_pkg::CFG_DATA_W-1:0] pwdata = '0;
	logic [lcdnw_pkg::CFG_DATA_W-1:0] prdata;
	logic        pready;

	char_lcd_nibble_writer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 8 unit clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// sequencer model: register copies and pin state
	// ---------------------------------------------------------------
	logic [15:0] pulse_len = lcdnw_pkg::PULSE_RESET;
	logic [23:0] settle_len = lcdnw_pkg::CMD_WAIT_RESET;
	logic [23:0] power_len = lcdnw_pkg::POWER_UP_RESET;

	lcdnw_pkg::phase_t lcd_ph = lcdnw_pkg::PH_IDLE;
	logic [23:0] tick_n = '0;      // ticks spent in the current phase
	logic [7:0]  held_val = '0;
	logic        held_rs = 1'b0;
	logic [1:0]  held_tgt = '0;
	logic [3:0]  boot_idx = '0;    // init command in flight
	logic        boot_on = 1'b0;

	// expected pin levels, oldest first
	lcdnw_pkg::result_t pin_levels_q [$];

	int cyc = 0;
	int errs = 0;
	int n_checked = 0;
	int n_writes = 0;
	int n_inits = 0;
	int n_refused = 0;
	int useful = 0;   // beats that do more than sit idle

	function automatic void load_byte(input logic [7:0] v, input logic rs,
			input logic [1:0] tgt);
		held_val = v;
		held_rs = rs;
		held_tgt = tgt;
		lcd_ph = lcdnw_pkg::PH_HI_EN;
		tick_n = '0;
	endfunction

	// byte done: next init command, or back to idle
	function automatic void next_byte();
		if (boot_on && boot_idx + 4'd1 < lcdnw_pkg::INIT_COUNT) begin
			boot_idx = boot_idx + 4'd1;
			load_byte(BOOT_SEQ[boot_idx], 1'b0, lcdnw_pkg::TGT_BOTH);
		end else begin
			boot_on = 1'b0;
			lcd_ph = lcdnw_pkg::PH_IDLE;
			tick_n = '0;
		end
	endfunction

	function automatic void end_phase();
		tick_n = '0;
		case (lcd_ph)
			lcdnw_pkg::PH_POWER: begin
				boot_idx = '0;
				load_byte(BOOT_SEQ[0], 1'b0, lcdnw_pkg::TGT_BOTH);
			end
			lcdnw_pkg::PH_HI_EN:  lcd_ph = lcdnw_pkg::PH_HI_GAP;
			lcdnw_pkg::PH_HI_GAP: lcd_ph = lcdnw_pkg::PH_LO_EN;
			lcdnw_pkg::PH_LO_EN:  lcd_ph = lcdnw_pkg::PH_LO_GAP;
			lcdnw_pkg::PH_LO_GAP: begin
				// only command bytes settle, and only with a nonzero wait
				if (!held_rs && settle_len != 0)
					lcd_ph = lcdnw_pkg::PH_SETTLE;
				else
					next_byte();
			end
			lcdnw_pkg::PH_SETTLE: next_byte();
			default:   lcd_ph = lcdnw_pkg::PH_IDLE;
		endcase
	endfunction

	function automatic void one_tick();
		int unsigned span;
		if (lcd_ph == lcdnw_pkg::PH_IDLE)
			return;
		if (lcd_ph == lcdnw_pkg::PH_POWER)
			span = power_len;
		else if (lcd_ph == lcdnw_pkg::PH_SETTLE)
			span = settle_len;
		else
			span = (pulse_len == 0) ? 1 : pulse_len;   // zero pulse acts as one tick
		tick_n = tick_n + 24'd1;
		if (int'(tick_n) >= span)
			end_phase();
	endfunction

	// advance the model by one beat and return the pin levels after it
	function automatic lcdnw_pkg::result_t lcd_pins_after(input lcdnw_pkg::item_t it);
		lcdnw_pkg::result_t r;
		logic took;
		logic en;
		took = 1'b0;
		case (it.action)
			lcdnw_pkg::ACT_TICK: one_tick();
			lcdnw_pkg::ACT_WRITE: begin
				if (lcd_ph == lcdnw_pkg::PH_IDLE) begin
					boot_on = 1'b0;
					load_byte(it.value, it.is_data, it.target);
					took = 1'b1;
				end
			end
			lcdnw_pkg::ACT_INIT: begin
				if (lcd_ph == lcdnw_pkg::PH_IDLE) begin
					boot_on = 1'b1;
					boot_idx = '0;
					tick_n = '0;
					if (power_len == 0)
						load_byte(BOOT_SEQ[0], 1'b0, lcdnw_pkg::TGT_BOTH);
					else
						lcd_ph = lcdnw_pkg::PH_POWER;
					took = 1'b1;
				end
			end
			default: ;
		endcase
		en = (lcd_ph == lcdnw_pkg::PH_HI_EN || lcd_ph == lcdnw_pkg::PH_LO_EN);
		r.data_nibble = (lcd_ph == lcdnw_pkg::PH_HI_EN || lcd_ph == lcdnw_pkg::PH_HI_GAP) ?
			held_val[7:4] : held_val[3:0];
		r.reg_select = held_rs;
		r.enable_one = en && (held_tgt == lcdnw_pkg::TGT_ONE ||
			held_tgt == lcdnw_pkg::TGT_BOTH);
		r.enable_two = en && (held_tgt == lcdnw_pkg::TGT_TWO ||
			held_tgt == lcdnw_pkg::TGT_BOTH);
		r.busy_res = (lcd_ph != lcdnw_pkg::PH_IDLE);
		r.accepted = took;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// run control: cycle count, hang limit, quiet window
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == RUN_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// both sides stream without gaps inside this window
	wire calm = (cyc >= 1800 && cyc < 2400);

	// ---------------------------------------------------------------
	// receive side: random stalls, one long hold-off to back up the input
	// ---------------------------------------------------------------
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && cyc >= 1000) begin
			hold_left <= 80;
			hold_done <= 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 19);
		end
	end

	// result checker: every beat against the oldest expectation
	always @(posedge clk) begin
		lcdnw_pkg::result_t got;
		lcdnw_pkg::result_t want;
		if (m_tvalid && m_tready) begin
			got = {m_tdata[3:0], m_tdata[4], m_tdata[5], m_tdata[6], m_tdata[7],
				m_tdata[8]};
			if (pin_levels_q.size() == 0) begin
				$error("result beat %h with nothing expected", m_tdata);
				errs++;
			end else begin
				want = pin_levels_q.pop_front();
				n_checked++;
				if (got.data_nibble !== want.data_nibble) begin
					$error("data_nibble exp %h got %h", want.data_nibble, got.data_nibble);
					errs++;
				end
				if (got.reg_select !== want.reg_select) begin
					$error("reg_select exp %b got %b", want.reg_select, got.reg_select);
					errs++;
				end
				if (got.enable_one !== want.enable_one) begin
					$error("enable_one exp %b got %b", want.enable_one, got.enable_one);
					errs++;
				end
				if (got.enable_two !== want.enable_two) begin
					$error("enable_two exp %b got %b", want.enable_two, got.enable_two);
					errs++;
				end
				if (got.busy_res !== want.busy_res) begin
					$error("busy_res exp %b got %b", want.busy_res, got.busy_res);
					errs++;
				end
				if (got.accepted !== want.accepted) begin
					$error("accepted exp %b got %b", want.accepted, got.accepted);
					errs++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// send side
	// ---------------------------------------------------------------

	// offer one beat, wait for the handshake, queue what it should produce;
	// called and left at a falling edge
	task automatic send_beat(input lcdnw_pkg::item_t it, input bit typed,
			input lcdnw_pkg::result_t typed_want);
		lcdnw_pkg::result_t r;
		if (!calm && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, it.target, it.is_data, it.value};
		s_tuser <= it.action;
		do @(posedge clk); while (!s_tready);
		if (lcd_ph != lcdnw_pkg::PH_IDLE || it.action == lcdnw_pkg::ACT_WRITE ||
				it.action == lcdnw_pkg::ACT_INIT)
			useful++;
		r = lcd_pins_after(it);
		if (it.action == lcdnw_pkg::ACT_WRITE || it.action == lcdnw_pkg::ACT_INIT) begin
			if (!r.accepted)
				n_refused++;
			else if (it.action == lcdnw_pkg::ACT_WRITE)
				n_writes++;
			else
				n_inits++;
		end
		pin_levels_q.push_back(typed ? typed_want : r);
		@(negedge clk);
	endtask

	// random beat: requests, ticks and some unused codes when idle, mostly time when busy
	function automatic lcdnw_pkg::item_t pick_item();
		lcdnw_pkg::item_t it;
		int unsigned roll;
		int unsigned t;
		roll = $urandom_range(99);
		t = $urandom_range(9);
		it.value = 8'($urandom_range(255));
		it.is_data = 1'($urandom_range(1));
		it.target = (t == 9) ? TGT_UNUSED : 2'(t % 3);
		if (lcd_ph == lcdnw_pkg::PH_IDLE)
			it.action = (roll < 40) ? lcdnw_pkg::ACT_WRITE :
				(roll < 52) ? lcdnw_pkg::ACT_INIT :
				(roll < 90) ? lcdnw_pkg::ACT_TICK : ACT_UNUSED;
		else
			it.action = (roll < 88) ? lcdnw_pkg::ACT_TICK :
				(roll < 94) ? lcdnw_pkg::ACT_WRITE :
				(roll < 98) ? lcdnw_pkg::ACT_INIT : ACT_UNUSED;
		return it;
	endfunction

	// stop offering, let every expected beat arrive, then idle on to the next step
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pin_levels_q.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// ---------------------------------------------------------------
	// register port
	// ---------------------------------------------------------------

	// one transfer, setup then access; rdata is taken at the access edge, then the
	// port sits idle before the next transfer
	task automatic reg_access(input logic wr, input logic [1:0] idx,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic reg_check(input logic [1:0] idx, input logic [31:0] want);
		logic [31:0] got;
		reg_access(1'b0, idx, '0, got);
		if (got !== want) begin
			$error("register %0d readback exp %h got %h", idx, want, got);
			errs++;
		end
	endtask

	task automatic cfg_set(input logic [1:0] idx, input logic [31:0] v);
		logic [31:0] unused_rd;
		logic [31:0] kept;
		reg_access(1'b1, idx, v, unused_rd);
		case (idx)
			lcdnw_pkg::REG_PULSE: begin
				pulse_len = v[15:0];
				kept = {16'b0, v[15:0]};
			end
			lcdnw_pkg::REG_CMD_WAIT: begin
				settle_len = v[23:0];
				kept = {8'b0, v[23:0]};
			end
			default: begin
				power_len = v[23:0];
				kept = {8'b0, v[23:0]};
			end
		endcase
		reg_check(idx, kept);
	endtask

	// ---------------------------------------------------------------
	// directed rows: typed expectations where they are obvious
	// ---------------------------------------------------------------
	typedef struct {
		lcdnw_pkg::item_t   it;
		bit                 typed;
		lcdnw_pkg::result_t want;   // {nibble, rs, en1, en2, busy, accepted}
	} row_t;

	row_t dir_rows [$];

	task automatic add_row(input logic [1:0] act, input logic [7:0] v, input logic rs,
			input logic [1:0] tgt, input bit typed, input lcdnw_pkg::result_t want);
		row_t rw;
		rw.it = '{action: act, value: v, is_data: rs, target: tgt};
		rw.typed = typed;
		rw.want = want;
		dir_rows.push_back(rw);
	endtask

	initial begin
		localparam lcdnw_pkg::result_t NONE = '0;
		int k;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// defaults after reset
		reg_check(lcdnw_pkg::REG_PULSE, {16'b0, lcdnw_pkg::PULSE_RESET});
		reg_check(lcdnw_pkg::REG_CMD_WAIT, {8'b0, lcdnw_pkg::CMD_WAIT_RESET});
		reg_check(lcdnw_pkg::REG_POWER_UP, {8'b0, lcdnw_pkg::POWER_UP_RESET});

		// shortest timing: zero pulse counts as one tick, no settle, no power-up wait
		cfg_set(lcdnw_pkg::REG_PULSE, 32'd0);
		cfg_set(lcdnw_pkg::REG_CMD_WAIT, 32'd0);
		cfg_set(lcdnw_pkg::REG_POWER_UP, 32'd0);

		// tick while idle changes nothing
		add_row(lcdnw_pkg::ACT_TICK, 8'h00, 1'b0, lcdnw_pkg::TGT_ONE, 1'b1,
			{4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0});
		// unused action code is ignored
		add_row(ACT_UNUSED, 8'hFF, 1'b1, TGT_UNUSED, 1'b1, NONE);
		// data byte to chip one: high nibble out, enable one up
		add_row(lcdnw_pkg::ACT_WRITE, 8'hA5, 1'b1, lcdnw_pkg::TGT_ONE, 1'b1,
			{4'hA, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1});
		// requests while busy are refused and take no time
		add_row(lcdnw_pkg::ACT_WRITE, 8'h12, 1'b0, lcdnw_pkg::TGT_TWO, 1'b0, NONE);
		add_row(lcdnw_pkg::ACT_INIT, 8'h00, 1'b0, lcdnw_pkg::TGT_ONE, 1'b0, NONE);
		add_row(ACT_UNUSED, 8'h00, 1'b0, lcdnw_pkg::TGT_ONE, 1'b0, NONE);
		for (k = 0; k < 4; k++)
			add_row(lcdnw_pkg::ACT_TICK, 8'h00, 1'b0, lcdnw_pkg::TGT_ONE, 1'b0, NONE);
		// command byte to chip two, settle skipped with zero wait
		add_row(lcdnw_pkg::ACT_WRITE, 8'h3C, 1'b0, lcdnw_pkg::TGT_TWO, 1'b0, NONE);
		for (k = 0; k < 4; k++)
			add_row(lcdnw_pkg::ACT_TICK, 8'h5A, 1'b1, lcdnw_pkg::TGT_BOTH, 1'b0, NONE);
		// all-ones data byte to both chips
		add_row(lcdnw_pkg::ACT_WRITE, 8'hFF, 1'b1, lcdnw_pkg::TGT_BOTH, 1'b1,
			{4'hF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1});
		for (k = 0; k < 4; k++)
			add_row(lcdnw_pkg::ACT_TICK, 8'h00, 1'b0, lcdnw_pkg::TGT_ONE, 1'b0, NONE);
		// unused target: bus toggles but no enable rises
		add_row(lcdnw_pkg::ACT_WRITE, 8'h00, 1'b0, TGT_UNUSED, 1'b1,
			{4'h0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1});
		add_row(lcdnw_pkg::ACT_TICK, 8'h00, 1'b0, lcdnw_pkg::TGT_ONE, 1'b0, NONE);
		add_row(lcdnw_pkg::ACT_TICK, 8'h00, 1'b0, lcdnw_pkg::TGT_ONE, 1'b0, NONE);
		add_row(lcdnw_pkg::ACT_TICK, 8'h00, 1'b0, lcdnw_pkg::TGT_ONE, 1'b0, NONE);
		add_row(lcdnw_pkg::ACT_TICK, 8'h00, 1'b0, lcdnw_pkg::TGT_ONE, 1'b0, NONE);
		// init with no power-up wait starts the first command at once
		add_row(lcdnw_pkg::ACT_INIT, 8'h00, 1'b0, lcdnw_pkg::TGT_ONE, 1'b1,
			{4'h3, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1});

		foreach (dir_rows[i])
			send_beat(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

		// random part over several small timing settings
		for (k = 0; k < SETTINGS_N; k++) begin
			while (useful < PHASE_BEATS * (k + 1))
				send_beat(pick_item(), 1'b0, NONE);
			// run the sequencer out so registers change only when idle
			while (lcd_ph != lcdnw_pkg::PH_IDLE)
				send_beat('{action: lcdnw_pkg::ACT_TICK, value: 8'($urandom_range(255)),
					is_data: 1'($urandom_range(1)), target: 2'($urandom_range(3))},
					1'b0, NONE);
			drain();
			cfg_set(lcdnw_pkg::REG_PULSE, (k == 4) ? 32'd0 : 32'($urandom_range(1, 4)));
			cfg_set(lcdnw_pkg::REG_CMD_WAIT, (k == 2) ? 32'd0 : 32'($urandom_range(1, 10)));
			cfg_set(lcdnw_pkg::REG_POWER_UP, (k == 3) ? 32'd0 : 32'($urandom_range(1, 12)));
		end

		// every register at its top: the first request never finishes in this run
		cfg_set(lcdnw_pkg::REG_PULSE, 32'h0000_FFFF);
		cfg_set(lcdnw_pkg::REG_CMD_WAIT, 32'h00FF_FFFF);
		cfg_set(lcdnw_pkg::REG_POWER_UP, 32'h00FF_FFFF);
		for (k = 0; k < TAIL_BEATS; k++)
			send_beat(pick_item(), 1'b0, NONE);
		drain();

		$display("checked %0d result beats over %0d timing settings", n_checked,
			SETTINGS_N + 1);
		$display("byte writes %0d, init runs %0d, refused requests %0d", n_writes, n_inits,
			n_refused);
		if (errs == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
